// ----- design/aafc_pkg.sv -----
`default_nettype none
package aafc_pkg;

	// matrix entry and plane coefficient formats
	localparam int MAT_W  = 32;
	localparam int COEF_W = MAT_W + 1;
	localparam int REG_W  = 2 * MAT_W;
	localparam int NUM_PLANES = 6;
	localparam int CFG_IDX_W  = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_COLS23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_COLS23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_COLS23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_COLS23 = 4'd7;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef coef_t [3:0] plane_coef_t;
	typedef plane_coef_t [NUM_PLANES-1:0] all_coef_t;

	// pipeline control shared by the datapath slices
	typedef struct packed {
		logic en;
	} pipe_ctl_t;

endpackage
`default_nettype wire

// ----- design/aafc_if.sv -----
`default_nettype none
interface aafc_box_if #(parameter int COORD_WIDTH = 32);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] box_min_x;
	logic signed [COORD_WIDTH-1:0] box_min_y;
	logic signed [COORD_WIDTH-1:0] box_min_z;
	logic signed [COORD_WIDTH-1:0] box_max_x;
	logic signed [COORD_WIDTH-1:0] box_max_y;
	logic signed [COORD_WIDTH-1:0] box_max_z;
	logic box_valid;
	modport source (output valid, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, box_valid, input ready);
	modport sink (input valid, box_min_x, box_min_y, box_min_z,
		box_max_x, box_max_y, box_max_z, box_valid, output ready);
endinterface

interface aafc_vis_if;
	logic valid;
	logic ready;
	logic visible;
	modport source (output valid, visible, input ready);
	modport sink (input valid, visible, output ready);
endinterface
`default_nettype wire

// ----- design/aabb_frustum_cull_unit.sv -----
// AABB frustum cull unit.
// box (sink): one axis-aligned box per beat, signed fixed-point corners
//   plus box_valid. res (source): one visible bit per box, in order.
// cfg_we/cfg_index/cfg_data write the 4x4 clip matrix, two Q16.16 entries
//   per 64-bit register; write only while the pipe is empty.
// Visible is 0 only when all eight corners lie strictly outside one of the
//   six clip planes; an invalid box is always visible.
// Throughput: one box per cycle while res is taken; the four-stage
//   pipeline (input register, 36 products, per-axis max, plane sum)
//   takes a box every cycle unless the output stalls.
// Stall: when res is not taken the whole pipe holds and box.ready drops
//   while the output register is full; nothing is dropped or repeated.
// Reset: pipe empties, matrix loads identity.
// Plane coefficients are registered from the matrix registers, so they follow a matrix write in the next cycle.
`default_nettype none
module aabb_frustum_cull_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	aafc_box_if.sink box,
	aafc_vis_if.source res,
	input  wire logic cfg_we,
	input  wire logic [aafc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aafc_pkg::REG_W-1:0] cfg_data
);

	aafc_pkg::all_coef_t coef_q;
	aafc_pkg::pipe_ctl_t ctl;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic bv_s1, bv_s2, bv_s3, bv_s4;
	logic signed [2:0][COORD_WIDTH-1:0] lo_s1, hi_s1;
	logic [aafc_pkg::NUM_PLANES-1:0] out_s4;

	aafc_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .coef_q(coef_q)
	);

	// whole pipe advances unless the result beat is stuck
	assign ctl.en = !vld_s4 || res.ready;
	assign box.ready = ctl.en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (ctl.en) begin
			vld_s1 <= box.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1 input register and box_valid delay line
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			lo_s1 <= {box.box_min_z, box.box_min_y, box.box_min_x};
			hi_s1 <= {box.box_max_z, box.box_max_y, box.box_max_x};
			bv_s1 <= box.box_valid;
			bv_s2 <= bv_s1;
			bv_s3 <= bv_s2;
			bv_s4 <= bv_s3;
		end
	end

	for (genvar p = 0; p < aafc_pkg::NUM_PLANES; p++) begin : g_plane
		aafc_plane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_plane (
			.clk(clk), .ctl(ctl), .coef(coef_q[p]), .lo(lo_s1), .hi(hi_s1),
			.all_out_s4(out_s4[p])
		);
	end

	assign res.valid = vld_s4;
	assign res.visible = !bv_s4 || !(|out_s4);

`ifndef ASSERT_OFF
	a_invalid_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !bv_s4) |-> res.visible)
		else $error("invalid box reported as culled");
	a_ready_only_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!box.ready |-> (vld_s4 && !res.ready))
		else $error("input blocked without output stall");
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(box.valid && box.ready) |=> vld_s1)
		else $error("accepted box not in stage 1");
`endif

endmodule
`default_nettype wire

// ----- design/aafc_cfg.sv -----
`default_nettype none
module aafc_cfg (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [aafc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [aafc_pkg::REG_W-1:0] cfg_data,
	output aafc_pkg::all_coef_t coef_q
);

	logic [aafc_pkg::REG_W-1:0] mat_q [8];

	// matrix registers, identity at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= 64'd65536;
			mat_q[1] <= 64'd0;
			mat_q[2] <= 64'd281474976710656;
			mat_q[3] <= 64'd0;
			mat_q[4] <= 64'd0;
			mat_q[5] <= 64'd65536;
			mat_q[6] <= 64'd0;
			mat_q[7] <= 64'd281474976710656;
		end else if (cfg_we) begin
			case (cfg_index)
				aafc_pkg::REG_ROW0_COLS01: mat_q[0] <= cfg_data;
				aafc_pkg::REG_ROW0_COLS23: mat_q[1] <= cfg_data;
				aafc_pkg::REG_ROW1_COLS01: mat_q[2] <= cfg_data;
				aafc_pkg::REG_ROW1_COLS23: mat_q[3] <= cfg_data;
				aafc_pkg::REG_ROW2_COLS01: mat_q[4] <= cfg_data;
				aafc_pkg::REG_ROW2_COLS23: mat_q[5] <= cfg_data;
				aafc_pkg::REG_ROW3_COLS01: mat_q[6] <= cfg_data;
				aafc_pkg::REG_ROW3_COLS23: mat_q[7] <= cfg_data;
				default: ;
			endcase
		end
	end

	function automatic aafc_pkg::coef_t entry(input logic [aafc_pkg::REG_W-1:0] r,
			input logic hi_half);
		logic signed [aafc_pkg::MAT_W-1:0] e;
		e = hi_half ? r[aafc_pkg::REG_W-1:aafc_pkg::MAT_W] : r[aafc_pkg::MAT_W-1:0];
		return aafc_pkg::COEF_W'(e);
	endfunction

	// plane coefficients: w row plus or minus the axis row, refreshed every cycle
	always_ff @(posedge clk) begin
		for (int p = 0; p < aafc_pkg::NUM_PLANES; p++) begin
			for (int c = 0; c < 4; c++) begin
				if (p % 2 == 1)
					coef_q[p][c] <= entry(mat_q[6 + c/2], c[0])
						- entry(mat_q[(p/2)*2 + c/2], c[0]);
				else
					coef_q[p][c] <= entry(mat_q[6 + c/2], c[0])
						+ entry(mat_q[(p/2)*2 + c/2], c[0]);
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/aafc_plane.sv -----
`default_nettype none
module aafc_plane #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire aafc_pkg::pipe_ctl_t ctl,
	input  wire aafc_pkg::plane_coef_t coef,
	input  wire logic signed [2:0][COORD_WIDTH-1:0] lo,
	input  wire logic signed [2:0][COORD_WIDTH-1:0] hi,
	output logic all_out_s4
);

	localparam int PW = aafc_pkg::COEF_W + COORD_WIDTH;
	localparam int CW3 = aafc_pkg::COEF_W + FRAC_BITS;
	localparam int SW = ((PW > CW3) ? PW : CW3) + 2;

	logic signed [2:0][PW-1:0] plo_s2, phi_s2;
	logic signed [2:0][PW-1:0] mx_s3;
	logic signed [SW-1:0] sum;

	// stage 2: both candidate products per axis
	// (elements of a packed array select unsigned, so re-sign them)
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int a = 0; a < 3; a++) begin
				plo_s2[a] <= PW'(coef[a]) * PW'($signed(lo[a]));
				phi_s2[a] <= PW'(coef[a]) * PW'($signed(hi[a]));
			end
		end
	end

	// stage 3: the worst corner maximizes each term independently
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			for (int a = 0; a < 3; a++)
				mx_s3[a] <= ($signed(phi_s2[a]) > $signed(plo_s2[a])) ? phi_s2[a] : plo_s2[a];
		end
	end

	// stage 4: largest plane value over the corners, outside if negative
	assign sum = (SW'(coef[3]) <<< FRAC_BITS) + SW'($signed(mx_s3[0]))
		+ SW'($signed(mx_s3[1])) + SW'($signed(mx_s3[2]));

	always_ff @(posedge clk) begin
		if (ctl.en)
			all_out_s4 <= sum[SW-1];
	end

endmodule
`default_nettype wire
